// ----- design/aip_pkg.sv -----
// aip_pkg: shared types and constants of the ascii integer parser
// no dependencies; used by the front, back and top level

package aip_pkg;

  localparam int MAX_STRING_LEN = 4096;
  localparam int POS_W          = $clog2(MAX_STRING_LEN);
  localparam int OFFS_W         = 12;
  localparam int OFFS_MAX       = 4095;
  localparam int CHAR_W         = 8;
  localparam int BASE_W         = 6;
  localparam int VALUE_W        = 64;
  localparam int QDEPTH         = 4;
  localparam int QA_W           = $clog2(QDEPTH);

  localparam logic [BASE_W-1:0] NOT_DIGIT = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_ONE  = BASE_W'(1);
  localparam logic [BASE_W-1:0] BASE_OCT  = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_DEC  = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX  = BASE_W'(16);

  typedef struct packed {
    logic [BASE_W-1:0] digit;
    logic              space;
    logic              plus;
    logic              minus;
    logic              zero;
    logic              ex;
  } char_class_t;

  typedef struct packed {
    logic              first;
    logic [BASE_W-1:0] base;
    char_class_t       cls;
  } q_entry_t;

endpackage

// ----- design/aip_in_if.sv -----
// aip_in_if: character channel, one byte of a string per transfer
// depends on nothing

interface aip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       first_char;
  logic [5:0] base_select;

  modport source (output valid, char_code, first_char, base_select, input ready);
  modport sink   (input valid, char_code, first_char, base_select, output ready);
endinterface

// ----- design/aip_out_if.sv -----
// aip_out_if: result channel, one parsed integer per transfer
// depends on nothing

interface aip_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic        [11:0] end_offset;
  logic               converted;

  modport source (output valid, value, end_offset, converted, input ready);
  modport sink   (input valid, value, end_offset, converted, output ready);
endinterface

// ----- design/aip_front.sv -----
// aip_front: classifies each incoming byte and holds it in a short queue
// depends on aip_pkg and aip_in_if

module aip_front (
  input  logic             clk,
  input  logic             rst_n,
  aip_in_if.sink           in_ch,
  output aip_pkg::q_entry_t q_data,
  output logic             q_valid,
  input  logic             q_pop
);
  import aip_pkg::*;

  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t r;
    r.digit = NOT_DIGIT;
    if (c >= "0" && c <= "9") begin
      r.digit = BASE_W'(c - "0");
    end else if (c >= "a" && c <= "z") begin
      r.digit = BASE_W'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "Z") begin
      r.digit = BASE_W'(c - "A" + 8'd10);
    end
    r.space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d) ||
              (c == 8'h0c) || (c == 8'h0b);
    r.plus  = (c == "+");
    r.minus = (c == "-");
    r.zero  = (c == "0");
    r.ex    = (c == "x") || (c == "X");
    return r;
  endfunction

  q_entry_t        q_mem_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QA_W:0]   count_r, count_nxt;
  logic            push;
  logic            pop;
  q_entry_t        entry;

  assign in_ch.ready = (count_r != (QA_W+1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_valid;
  assign q_valid     = (count_r != '0);
  assign q_data      = q_mem_r[rd_ptr_r];

  always_comb begin
    entry.first = in_ch.first_char;
    entry.base  = in_ch.base_select;
    entry.cls   = classify(in_ch.char_code);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end
endmodule

// ----- design/aip_back.sv -----
// aip_back: parse engine stepping one classified byte per cycle, with result register; a result not yet taken stalls it
// depends on aip_pkg and aip_out_if

module aip_back (
  input  logic              clk,
  input  logic              rst_n,
  input  aip_pkg::q_entry_t q_data,
  input  logic              q_valid,
  output logic              q_pop,
  aip_out_if.source         out_ch
);
  import aip_pkg::*;

  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_WS     = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_HEX    = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LEN-1);

  logic [2:0]         phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   endm_r, endm_nxt;
  logic               seen_r, seen_nxt;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [OFFS_W-1:0]  out_end_r;
  logic               out_conv_r;

  logic [VALUE_W-1:0] mul;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W-1:0]   pos_adv;
  logic [BASE_W-1:0]  bb;
  logic               fin;
  logic [VALUE_W-1:0] fin_value;
  logic [OFFS_W-1:0]  fin_end;
  logic [31:0]        endm_ext;
  logic               start_num;
  char_class_t        cl;

  assign q_pop   = q_valid && (!out_valid_r || out_ch.ready);
  assign cl      = q_data.cls;
  assign mul     = VALUE_W'(acc_r * base_r);
  // position of this byte, cleared when it starts a new string
  assign pos_cur = q_data.first ? '0 : pos_r;
  assign pos_adv = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    base_nxt  = base_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    endm_nxt  = endm_r;
    seen_nxt  = seen_r;
    fin       = 1'b0;
    start_num = 1'b0;
    bb        = base_r;
    if (q_data.first) begin
      neg_nxt   = 1'b0;
      base_nxt  = q_data.base;
      acc_nxt   = '0;
      pos_nxt   = '0;
      endm_nxt  = '0;
      seen_nxt  = 1'b0;
      phase_nxt = PH_WS;
    end
    if (q_data.first && (q_data.base == BASE_ONE || q_data.base > BASE_MAX)) begin
      fin = 1'b1;
    end else begin
      unique case (phase_nxt)
        PH_WS: begin
          if (cl.space) begin
            pos_nxt = pos_adv;
          end else if (cl.plus || cl.minus) begin
            neg_nxt   = cl.minus;
            phase_nxt = PH_SIGN;
            pos_nxt   = pos_adv;
          end else begin
            start_num = 1'b1;
          end
        end
        PH_SIGN: start_num = 1'b1;
        PH_ZERO: begin
          if (cl.ex) begin
            phase_nxt = PH_HEX;
            pos_nxt   = pos_adv;
          end else begin
            bb        = (base_nxt == BASE_AUTO) ? BASE_OCT : base_nxt;
            base_nxt  = bb;
            phase_nxt = PH_DIGITS;
            if (cl.digit < bb) begin
              acc_nxt  = VALUE_W'(cl.digit);
              seen_nxt = 1'b1;
              endm_nxt = pos_adv;
              pos_nxt  = pos_adv;
            end else begin
              fin = 1'b1;
            end
          end
        end
        PH_HEX: begin
          base_nxt = BASE_HEX;
          if (cl.digit < BASE_HEX) begin
            acc_nxt   = VALUE_W'(cl.digit);
            seen_nxt  = 1'b1;
            endm_nxt  = pos_adv;
            pos_nxt   = pos_adv;
            phase_nxt = PH_DIGITS;
          end else begin
            fin = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (cl.digit < base_r) begin
            acc_nxt  = mul + VALUE_W'(cl.digit);
            seen_nxt = 1'b1;
            endm_nxt = pos_adv;
            pos_nxt  = pos_adv;
          end else begin
            fin = 1'b1;
          end
        end
        default: ;
      endcase
      if (start_num) begin
        if (cl.zero && (base_nxt == BASE_AUTO || base_nxt == BASE_HEX)) begin
          acc_nxt   = '0;
          seen_nxt  = 1'b1;
          endm_nxt  = pos_adv;
          pos_nxt   = pos_adv;
          phase_nxt = PH_ZERO;
        end else begin
          bb = (base_nxt == BASE_AUTO) ? BASE_DEC : base_nxt;
          if (cl.digit < bb) begin
            base_nxt  = bb;
            acc_nxt   = VALUE_W'(cl.digit);
            seen_nxt  = 1'b1;
            endm_nxt  = pos_adv;
            pos_nxt   = pos_adv;
            phase_nxt = PH_DIGITS;
          end else begin
            fin = 1'b1;
          end
        end
      end
    end
    if (fin) begin
      phase_nxt = PH_DONE;
    end
  end

  // result of a finished parse, from the state after this byte's update
  always_comb begin
    endm_ext  = 32'(endm_nxt);
    fin_value = '0;
    fin_end   = '0;
    if (seen_nxt) begin
      fin_value = neg_nxt ? (VALUE_W'(0) - acc_nxt) : acc_nxt;
      fin_end   = (endm_ext > 32'(OFFS_MAX)) ? OFFS_W'(OFFS_MAX) : endm_ext[OFFS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      neg_r       <= 1'b0;
      base_r      <= '0;
      acc_r       <= '0;
      pos_r       <= '0;
      endm_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        acc_r   <= acc_nxt;
        pos_r   <= pos_nxt;
        endm_r  <= endm_nxt;
        seen_r  <= seen_nxt;
      end
      if (q_pop && fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && fin) begin
      out_value_r <= fin_value;
      out_end_r   <= fin_end;
      out_conv_r  <= seen_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.end_offset = out_end_r;
  assign out_ch.converted  = out_conv_r;
endmodule

// ----- design/ascii_integer_parser_top.sv -----
// ascii_integer_parser_top: streaming strtol-style parser, front queue plus parse engine
// depends on aip_pkg, aip_in_if, aip_out_if, aip_front and aip_back
//
//   port     direction  carries
//   in_ch    sink       char_code[7:0], first_char, base_select[5:0]
//   out_ch   source     value[63:0] signed, end_offset[11:0], converted
//
// one byte per cycle while results drain; the engine's 64x6 multiply-add sets the cycle
// a byte reaches the engine through a 4-entry queue, registered in the queue memory
// the result appears in the cycle after its terminating byte is processed
// reset is synchronous, active low, and needs no further sweep
// a stalled result holds the engine only; the queue keeps taking bytes until full

module ascii_integer_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  aip_in_if.sink     in_ch,
  aip_out_if.source  out_ch
);
  import aip_pkg::*;

  q_entry_t q_data;
  logic     q_valid;
  logic     q_pop;

  aip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  aip_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule
